FILE: rtl/ntc_pkg.sv
// Shared types and constants for the NTC thermistor temperature converter.
// No dependencies; imported by ntc_ctrl, ntc_dp and ntc_adc_to_temperature.
package ntc_pkg;

   localparam int SUM_W   = 16;
   localparam int COUNT_W = 4;
   localparam int CSR_W   = 8;
   localparam int WDATA_W = 20;
   localparam int TEMP_W  = 19;

   localparam logic [CSR_W-1:0] CSR_SERIES_RES  = 8'd0;
   localparam logic [CSR_W-1:0] CSR_NOMINAL_RES = 8'd1;
   localparam logic [CSR_W-1:0] CSR_BETA        = 8'd2;
   localparam logic [CSR_W-1:0] CSR_NOMINAL_T   = 8'd3;

   localparam logic [19:0]        RST_SERIES_RES  = 20'd10000;
   localparam logic [19:0]        RST_NOMINAL_RES = 20'd50000;
   localparam logic [13:0]        RST_BETA        = 14'd3976;
   localparam logic signed [14:0] RST_NOMINAL_T   = 15'sd2500;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SHORT = 2'd1;
   localparam logic [1:0] STATUS_OPEN  = 2'd2;

   localparam logic signed [16:0]       KELVIN_OFFSET = 17'sd27315;
   localparam logic [29:0]              LN2_Q30       = 30'd744261118;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH     = 19'sd200000;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW      = -19'sd10000;
   localparam logic signed [TEMP_W-1:0] TEMP_SHORTED  = -19'sd100;
   localparam logic signed [TEMP_W-1:0] TEMP_OPENED   = -19'sd200;
   // kelvin-side limits, centikelvin
   localparam logic [18:0] TC_HIGH = 19'd227315;
   localparam logic [18:0] TC_LOW  = 19'd17315;

   localparam int NORM_STEPS = 6;
   localparam int FRAC_BITS  = 24;
   localparam int QUOT_BITS  = 19;

   typedef struct packed {
      logic [19:0]        series_res;
      logic [19:0]        nominal_res;
      logic [13:0]        beta;
      logic signed [14:0] nominal_temp;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_NORM,
      OP_SQR,
      OP_LN,
      OP_LQ,
      OP_TL,
      OP_DEN,
      OP_OVF,
      OP_DIV,
      OP_FIN
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic special;
   } dp_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_SQR,
      ST_LN,
      ST_LQ,
      ST_TL,
      ST_DEN,
      ST_OVF,
      ST_DIV,
      ST_FIN
   } ctrl_state_type;

endpackage

FILE: rtl/ntc_dp.sv
// Conversion datapath: products, two log2 lanes, ln scaling, beta equation
// and a restoring divider, stepped by ntc_ctrl. Depends on ntc_pkg.
module ntc_dp import ntc_pkg::*; #(
   parameter int SAMPLES_PER_READING = 5,
   parameter int ADC_FULL_SCALE      = 4095
) (
   input  logic                     clock,
   input  dp_cmd_type               cmd,
   input  logic [SUM_W-1:0]         sum,
   input  cfg_type                  cfg,
   output dp_stat_type              stat,
   output logic signed [TEMP_W-1:0] rsp_temp_centi,
   output logic [1:0]               rsp_status
);

   localparam logic [15:0] NF          = 16'(SAMPLES_PER_READING * ADC_FULL_SCALE);
   localparam logic [16:0] SHORT_LIMIT = 17'(SAMPLES_PER_READING);
   localparam logic [16:0] OPEN_LIMIT  =
      17'(SAMPLES_PER_READING * (2 * ADC_FULL_SCALE - 1));

   logic [SUM_W-1:0]         s_ff;
   logic                     special_ff;
   logic signed [TEMP_W-1:0] spec_temp_ff;
   logic [1:0]               spec_status_ff;
   logic [35:0]              xa_ff, xb_ff;
   logic [5:0]               ea_ff, eb_ff;
   logic [31:0]              ya_ff, yb_ff;
   logic [FRAC_BITS-1:0]     fa_ff, fb_ff;
   logic [15:0]              t0_ff;
   logic [20:0]              b100_ff;
   logic                     neg_ff;
   logic [59:0]              prod_ff;
   logic signed [30:0]       lq_ff;
   logic [36:0]              bt_ff;
   logic signed [47:0]       tl_ff;
   logic signed [48:0]       d_ff;
   logic [61:0]              rem_ff;
   logic [67:0]              dv_ff;
   logic                     ovf_ff;
   logic                     nonpos_ff;
   logic [QUOT_BITS-1:0]     q_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [1:0]               status_ff;

   logic                     is_short, is_open;
   logic signed [16:0]       t0_full;
   logic [41:0]              norm_a, norm_b;
   logic [32:0]              sq_a, sq_b;
   logic signed [30:0]       l2;
   logic [29:0]              mag;
   logic [29:0]              lq_mag;
   logic [61:0]              numer;
   logic                     rem_ge;
   logic signed [19:0]       tc_signed;
   logic signed [TEMP_W-1:0] temp_calc;

   // one binary-search step of the leading-one normalization
   function automatic logic [41:0] norm_step(input logic [35:0] x, input logic [5:0] e,
                                             input logic [2:0] k);
      logic [35:0] xo;
      logic [5:0]  eo;
      xo = x;
      eo = e;
      unique case (k)
         3'd0: if (x[35:4] == 32'd0) begin
            xo = x << 32;
            eo = e - 6'd32;
         end
         3'd1: if (x[35:20] == 16'd0) begin
            xo = x << 16;
            eo = e - 6'd16;
         end
         3'd2: if (x[35:28] == 8'd0) begin
            xo = x << 8;
            eo = e - 6'd8;
         end
         3'd3: if (x[35:32] == 4'd0) begin
            xo = x << 4;
            eo = e - 6'd4;
         end
         3'd4: if (x[35:34] == 2'd0) begin
            xo = x << 2;
            eo = e - 6'd2;
         end
         default: if (!x[35]) begin
            xo = x << 1;
            eo = e - 6'd1;
         end
      endcase
      return {eo, xo};
   endfunction

   // square the Q31 mantissa; top bit is the next fraction bit of log2
   function automatic logic [32:0] sq_step(input logic [31:0] y);
      logic [63:0] p;
      logic [32:0] t;
      p = 64'(y) * 64'(y);
      t = p[63:31];
      if (t[32]) begin
         return {1'b1, t[32:1]};
      end
      return {1'b0, t[31:0]};
   endfunction

   assign is_short = {1'b0, sum, 1'b0} <= {1'b0, SHORT_LIMIT};
   assign is_open  = {1'b0, sum, 1'b0} >= {1'b0, OPEN_LIMIT};
   assign t0_full  = 17'(cfg.nominal_temp) + KELVIN_OFFSET;

   assign norm_a = norm_step(xa_ff, ea_ff, cmd.step);
   assign norm_b = norm_step(xb_ff, eb_ff, cmd.step);
   assign sq_a   = sq_step(ya_ff);
   assign sq_b   = sq_step(yb_ff);

   assign l2     = $signed({1'b0, ea_ff, fa_ff}) - $signed({1'b0, eb_ff, fb_ff});
   assign mag    = l2[30] ? 30'(-l2) : l2[29:0];
   assign lq_mag = 30'((prod_ff + 60'd536870912) >> 30);

   assign numer  = {1'b0, bt_ff, 24'd0} + 62'(d_ff[47:1]);
   assign rem_ge = {6'd0, rem_ff} >= dv_ff;

   assign tc_signed = $signed({1'b0, q_ff}) - 20'(KELVIN_OFFSET);

   always_comb begin
      priority if (nonpos_ff || ovf_ff || q_ff > TC_HIGH) begin
         temp_calc = TEMP_HIGH;
      end else if (q_ff < TC_LOW) begin
         temp_calc = TEMP_LOW;
      end else begin
         temp_calc = tc_signed[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            s_ff       <= sum;
            t0_ff      <= t0_full[15:0];
            b100_ff    <= 21'(cfg.beta) * 21'd100;
            priority if (is_short) begin
               special_ff     <= 1'b1;
               spec_temp_ff   <= TEMP_SHORTED;
               spec_status_ff <= STATUS_SHORT;
            end else if (is_open) begin
               special_ff     <= 1'b1;
               spec_temp_ff   <= TEMP_OPENED;
               spec_status_ff <= STATUS_OPEN;
            end else if (cfg.series_res == 20'd0) begin
               special_ff     <= 1'b1;
               spec_temp_ff   <= TEMP_HIGH;
               spec_status_ff <= STATUS_OK;
            end else if (cfg.nominal_res == 20'd0) begin
               special_ff     <= 1'b1;
               spec_temp_ff   <= TEMP_LOW;
               spec_status_ff <= STATUS_OK;
            end else begin
               special_ff     <= 1'b0;
               spec_status_ff <= STATUS_OK;
            end
         end
         OP_MUL: begin
            xa_ff <= 36'(cfg.series_res) * 36'(s_ff);
            xb_ff <= 36'(cfg.nominal_res) * 36'(NF - s_ff);
            ea_ff <= 6'd35;
            eb_ff <= 6'd35;
         end
         OP_NORM: begin
            {ea_ff, xa_ff} <= norm_a;
            {eb_ff, xb_ff} <= norm_b;
            ya_ff <= norm_a[35:4];
            yb_ff <= norm_b[35:4];
         end
         OP_SQR: begin
            ya_ff <= sq_a[31:0];
            yb_ff <= sq_b[31:0];
            fa_ff <= {fa_ff[FRAC_BITS-2:0], sq_a[32]};
            fb_ff <= {fb_ff[FRAC_BITS-2:0], sq_b[32]};
         end
         OP_LN: begin
            neg_ff  <= l2[30];
            prod_ff <= 60'(mag) * 60'(LN2_Q30);
         end
         OP_LQ: begin
            lq_ff <= neg_ff ? -$signed({1'b0, lq_mag}) : $signed({1'b0, lq_mag});
            bt_ff <= 37'(b100_ff) * 37'(t0_ff);
         end
         OP_TL: begin
            tl_ff <= 48'($signed({1'b0, t0_ff})) * 48'(lq_ff);
         end
         OP_DEN: begin
            d_ff <= $signed({4'd0, b100_ff, 24'd0}) + 49'(tl_ff);
         end
         OP_OVF: begin
            nonpos_ff <= d_ff[48] || (d_ff == 49'sd0);
            rem_ff    <= numer;
            ovf_ff    <= {6'd0, numer} >= {1'b0, d_ff[47:0], 19'd0};
            dv_ff     <= {2'd0, d_ff[47:0], 18'd0};
            q_ff      <= '0;
         end
         OP_DIV: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - dv_ff[61:0];
            end
            q_ff  <= {q_ff[QUOT_BITS-2:0], rem_ge};
            dv_ff <= dv_ff >> 1;
         end
         OP_FIN: begin
            temp_ff   <= special_ff ? spec_temp_ff : temp_calc;
            status_ff <= special_ff ? spec_status_ff : STATUS_OK;
         end
         default: begin
         end
      endcase
   end

   assign stat.special   = special_ff;
   assign rsp_temp_centi = temp_ff;
   assign rsp_status     = status_ff;

endmodule

FILE: rtl/ntc_ctrl.sv
// Sequencer for the conversion: issues datapath commands, counts steps and
// owns the result valid flag. Depends on ntc_pkg.
module ntc_ctrl import ntc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   ctrl_state_type state_ff, state_in;
   logic [4:0]     step_ff, step_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff[2:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = '0;
            if (stat.special) begin
               state_in = ST_FIN;
            end else begin
               cmd.op   = OP_MUL;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.op  = OP_NORM;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(NORM_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cmd.op  = OP_SQR;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(FRAC_BITS - 1)) begin
               step_in  = '0;
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            cmd.op   = OP_LN;
            state_in = ST_LQ;
         end
         ST_LQ: begin
            cmd.op   = OP_LQ;
            state_in = ST_TL;
         end
         ST_TL: begin
            cmd.op   = OP_TL;
            state_in = ST_DEN;
         end
         ST_DEN: begin
            cmd.op   = OP_DEN;
            state_in = ST_OVF;
         end
         ST_OVF: begin
            cmd.op   = OP_OVF;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(QUOT_BITS - 1)) begin
               step_in  = '0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_FIN;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/ntc_adc_to_temperature.sv
// Top level of the NTC thermistor converter: register file, sample
// accumulator, ntc_ctrl and ntc_dp. Depends on ntc_pkg.
//
//   port group  dir  contents
//   req_*       in   sample (12b), valid/stall
//   rsp_*       out  temp_centi (19b signed), status (2b), valid/stall
//   csr_*       in   index (8b), wdata (20b), valid/ready
//
// A sample that does not close a group only updates the accumulator. The sample
// that closes a group starts a conversion: for a normal reading 6 normalize
// steps and 24 log2 squarings on both lanes, 19 divider steps and the scaling
// stages; a fault reading skips them. req_stall is high meanwhile.
// A finished result waits in the output register while rsp_stall is high;
// samples are still taken. Reset loads the default register values.
module ntc_adc_to_temperature import ntc_pkg::*; #(
   parameter int SAMPLES_PER_READING = 5,
   parameter int ADC_FULL_SCALE      = 4095
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [11:0]              req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_temp_centi,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [WDATA_W-1:0]       csr_wdata
);

   cfg_type             cfg_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W:0]    count_in;
   logic                accept, last, start, busy;
   dp_cmd_type          cmd;
   dp_stat_type         stat;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign sum_in    = sum_ff + SUM_W'(req_sample);
   assign count_in  = {1'b0, count_ff} + 5'd1;
   assign last      = count_in == 5'(SAMPLES_PER_READING);
   assign start     = accept && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.series_res   <= RST_SERIES_RES;
         cfg_ff.nominal_res  <= RST_NOMINAL_RES;
         cfg_ff.beta         <= RST_BETA;
         cfg_ff.nominal_temp <= RST_NOMINAL_T;
         sum_ff              <= '0;
         count_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SERIES_RES:  cfg_ff.series_res   <= csr_wdata;
               CSR_NOMINAL_RES: cfg_ff.nominal_res  <= csr_wdata;
               CSR_BETA:        cfg_ff.beta         <= csr_wdata[13:0];
               CSR_NOMINAL_T:   cfg_ff.nominal_temp <= $signed(csr_wdata[14:0]);
               default: begin
               end
            endcase
         end
         if (accept) begin
            // clear the group once its last request is in
            if (last) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in[COUNT_W-1:0];
            end
         end
      end
   end

   ntc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ntc_dp #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING),
      .ADC_FULL_SCALE      (ADC_FULL_SCALE)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .sum            (sum_in),
      .cfg            (cfg_ff),
      .stat           (stat),
      .rsp_temp_centi (rsp_temp_centi),
      .rsp_status     (rsp_status)
   );

endmodule

FILE: test/ntc_adc_to_temperature_tb.sv
// Testbench for ntc_adc_to_temperature: directed groups of samples, then random groups
// under several register settings, each reading checked against a local beta-equation model.
// Depends on ntc_pkg and the ntc_adc_to_temperature RTL.
module ntc_adc_to_temperature_tb;
   import ntc_pkg::*;

   localparam int GROUP     = 5;
   localparam int FULL      = 4095;
   localparam int SETTLE    = 60;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic signed [TEMP_W-1:0] temp;
      logic [1:0]               status;
   } reading_type;

   typedef struct {
      logic [11:0]              sample;
      bit                       typed;
      logic signed [TEMP_W-1:0] temp;
      logic [1:0]               status;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [11:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0] rsp_temp_centi;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic [WDATA_W-1:0] csr_wdata = '0;

   reading_type readings_due[$];
   cfg_type  model_cfg;
   logic [15:0] model_sum;
   logic [3:0]  model_cnt;
   int errors = 0;
   int burst_left = 0;
   bit long_hold = 0;
   int hold_cnt = 0;
   int rx_cycle = 0;
   int rx_mode = 0;

   ntc_adc_to_temperature dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

   function automatic longint log2_q24(longint unsigned x);
      int e = 63;
      longint unsigned y;
      longint unsigned fr = 0;
      while (e > 0 && x[e] == 1'b0) e--;
      if (e >= 31) y = x >> (e - 31);
      else y = x << (31 - e);
      for (int i = 23; i >= 0; i--) begin
         y = (y * y) >> 31;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            fr[i] = 1'b1;
         end
      end
      return (longint'(e) <<< 24) + longint'(fr);
   endfunction

   function automatic logic signed [TEMP_W-1:0] beta_temp(longint unsigned s);
      longint unsigned rs = model_cfg.series_res;
      longint unsigned rn = model_cfg.nominal_res;
      longint unsigned b = model_cfg.beta;
      longint t0 = longint'(model_cfg.nominal_temp) + 27315;
      longint l2, lq, d, tcs;
      longint unsigned mag, num, tc;
      if (rs == 0) return TEMP_HIGH;
      if (rn == 0) return TEMP_LOW;
      l2 = log2_q24(rs * s) - log2_q24(rn * (GROUP * FULL - s));
      mag = (l2 < 0) ? longint'(-l2) : longint'(l2);
      mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
      lq = (l2 < 0) ? -longint'(mag) : longint'(mag);
      d = longint'(100 * b) * (64'sd1 <<< 24) + t0 * lq;
      if (d <= 0) return TEMP_HIGH;
      num = (64'd100 * b * longint'(t0)) << 24;
      tc = (num + longint'(d) / 2) / longint'(d);
      if (tc > 27315 + 200000) return TEMP_HIGH;
      tcs = longint'(tc) - 27315;
      if (tcs < -10000) return TEMP_LOW;
      return tcs[TEMP_W-1:0];
   endfunction

   // Advance the accumulator; return 1 with the reading when a group closes.
   function automatic bit accumulate(logic [11:0] smp, output reading_type r);
      logic [15:0] s;
      model_sum = model_sum + 16'(smp);
      if (model_cnt + 1 < GROUP) begin
         model_cnt = model_cnt + 1;
         return 0;
      end
      s = model_sum;
      model_sum = '0;
      model_cnt = '0;
      if (2 * s <= GROUP) begin
         r.temp = TEMP_SHORTED;
         r.status = STATUS_SHORT;
      end else if (2 * s >= GROUP * (2 * FULL - 1)) begin
         r.temp = TEMP_OPENED;
         r.status = STATUS_OPEN;
      end else begin
         r.temp = beta_temp(s);
         r.status = STATUS_OK;
      end
      return 1;
   endfunction

   task automatic offer_sample(logic [11:0] smp, bit typed = 0, reading_type want = '{0, 0});
      reading_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      if (accumulate(smp, r)) readings_due.push_back(typed ? want : r);
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   task automatic drain();
      end_burst();
      wait (readings_due.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_W-1:0] idx, logic [WDATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SERIES_RES:  model_cfg.series_res = data;
         CSR_NOMINAL_RES: model_cfg.nominal_res = data;
         CSR_BETA:        model_cfg.beta = data[13:0];
         CSR_NOMINAL_T:   model_cfg.nominal_temp = data[14:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_cfg(logic [19:0] rs, logic [19:0] rn, logic [13:0] b,
                           logic signed [14:0] t0);
      csr_write(CSR_SERIES_RES, rs);
      csr_write(CSR_NOMINAL_RES, rn);
      csr_write(CSR_BETA, 20'(b));
      csr_write(CSR_NOMINAL_T, 20'($unsigned(t0)));
   endtask

   function automatic logic [11:0] pick_sample(int regime);
      case (regime)
         0: return 12'($urandom_range(0, 3));
         1: return 12'($urandom_range(4092, 4095));
         2: return 12'($urandom_range(1500, 2600));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Receiver: the stall pattern is redrawn at random from three modes, plus one long hold-off.
   always @(posedge clock) begin
      reading_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readings_due.size() == 0) begin
            $error("unexpected reading temp_centi=%0d status=%0d", rsp_temp_centi, rsp_status);
            errors++;
         end else begin
            w = readings_due.pop_front();
            if (rsp_temp_centi !== w.temp) begin
               $error("temp_centi expected %0d actual %0d", w.temp, rsp_temp_centi);
               errors++;
            end
            if (rsp_status !== w.status) begin
               $error("status expected %0d actual %0d", w.status, rsp_status);
               errors++;
            end
         end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (long_hold && hold_cnt < LONG_HOLD) begin
         hold_cnt++;
         rsp_stall <= 1'b1;
      end else begin
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   row_type directed[25];

   initial begin
      reading_type want;
      int regime;
      model_cfg = '{RST_SERIES_RES, RST_NOMINAL_RES, RST_BETA, RST_NOMINAL_T};
      model_sum = '0;
      model_cnt = '0;
      for (int i = 0; i < 25; i++) directed[i] = '{12'd0, 0, '0, STATUS_OK};
      // shorted group, then smallest sum that still converts
      directed[4] = '{12'd0, 1, TEMP_SHORTED, STATUS_SHORT};
      directed[5].sample = 12'd1;
      directed[6].sample = 12'd1;
      directed[7].sample = 12'd1;
      // open group, then largest sum that still converts
      for (int i = 10; i < 20; i++) directed[i].sample = 12'd4095;
      directed[14] = '{12'd4095, 1, TEMP_OPENED, STATUS_OPEN};
      directed[19].sample = 12'd4092;
      for (int i = 20; i < 25; i++) directed[i].sample = 12'd2048;
      directed[22].sample = 12'hAAA;
      directed[23].sample = 12'h555;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         offer_sample(directed[i].sample, directed[i].typed,
                      '{directed[i].temp, directed[i].status});
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: load_cfg(20'd1, 20'd1000000, 14'd1000, -15'sd4000);
            1: load_cfg(20'd1000000, 20'd1, 14'd10000, 15'sd15000);
            2: load_cfg(20'd0, 20'd50000, 14'd3976, 15'sd2500);
            3: load_cfg(20'd10000, 20'd0, 14'd3976, 15'sd2500);
            4: load_cfg(20'hFFFFF, 20'hFFFFF, 14'h3FFF, -15'sd16384);
            5: load_cfg(20'd10000, 20'd10000, 14'd0, 15'sd16383);
            6: begin
               load_cfg(RST_SERIES_RES, RST_NOMINAL_RES, RST_BETA, RST_NOMINAL_T);
               csr_write(CSR_W'($urandom_range(4, 255)), 20'($urandom));
            end
            default: load_cfg(20'($urandom_range(1, 1000000)),
                              20'($urandom_range(1, 1000000)),
                              14'($urandom_range(1000, 10000)),
                              15'($signed($urandom_range(0, 19000)) - 4000));
         endcase
         if (phase == 1) long_hold = 1;
         for (int g = 0; g < 31; g++) begin
            regime = $urandom_range(0, 9);
            if (regime > 3) regime = 3;
            for (int k = 0; k < GROUP; k++)
               offer_sample(($urandom_range(0, 19) == 0) ? 12'($urandom) :
                            pick_sample(regime));
         end
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
